// ===== hdl/chassis_power_limiter_unit_defines.svh =====
// Assertion macros used by the power limiter top level.
// No dependencies; the using module provides clk and rst_n.
`ifndef CHASSIS_POWER_LIMITER_UNIT_DEFINES_SVH
`define CHASSIS_POWER_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CPL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles
`define CPL_ASSERT_DLY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

// ===== hdl/cpl_pkg.sv =====
// Shared types, constants and Q16.16 helpers of the chassis power limiter.
// No dependencies.
package cpl_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int QUAD_FACTOR = 4;
    localparam int CMD_MAX     = 16384;

    // Wide signed width for exact intermediate products and sums
    localparam int WIDE_W = 68;

    // Total power and divider widths
    localparam int TOT_W = 32 + $clog2(MOTOR_COUNT);
    localparam int CMP_W = TOT_W + 1;
    localparam int DEN_W = TOT_W - 1;
    localparam int REM_W = DEN_W + 1;

    // Divider: 32 quotient bits, DIV_BITS per stage
    localparam int DIV_BITS = 4;
    localparam int DIV_STG  = 32 / DIV_BITS;

    // Square root of a 48-bit radicand: 24 root bits, SQ_BITS per stage
    localparam int RAD_W   = 48;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SQREM_W = ROOT_W + 3;
    localparam int SQ_BITS = 4;
    localparam int SQ_STG  = ROOT_W / SQ_BITS;

    // Pipeline latencies
    localparam int PWR_LAT   = 4;
    localparam int SOLVE_LAT = 8 + DIV_STG + SQ_STG;
    localparam int PIPE_LAT  = PWR_LAT + SOLVE_LAT;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TORQUE_PER_CURRENT  = 3'd0,
        REG_SPEED_POWER_FACTOR  = 3'd1,
        REG_CURRENT_PER_TORQUE  = 3'd2,
        REG_SPEED_LOSS_GAIN     = 3'd3,
        REG_TORQUE_LOSS_GAIN    = 3'd4,
        REG_STATIC_LOSS         = 3'd5,
        REG_INV_TWO_TORQUE_GAIN = 3'd6
    } reg_idx_t;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        q_t tc;
        q_t mc;
        q_t ic;
        q_t kw;
        q_t kt;
        q_t a;
        q_t inv2kt;
    } cfg_t;

    // Per-motor power model results handed to the solver
    typedef struct packed {
        q_t                 pin;
        q_t                 wmc;
        q_t                 w2;
        q_t                 kw2a;
        logic signed [15:0] cur;
    } pwr_t;

    // Per-motor solver result
    typedef struct packed {
        logic signed [15:0] current;
        logic               sat;
        logic               limited;
    } res_t;

    // Saturate a wide signed value to 32 bits
    function automatic q_t sat32(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-32:0] top;
        top = x[WIDE_W-1:31];
        if (top == '0 || top == '1)
            return x[31:0];
        else if (x[WIDE_W-1])
            return 32'sh8000_0000;
        else
            return 32'sh7fff_ffff;
    endfunction

    // Q16.16 product, floor shift, saturate
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [WIDE_W-1:0] p;
        p = (WIDE_W'(a) * WIDE_W'(b)) >>> 16;
        return sat32(p);
    endfunction

endpackage

// ===== hdl/cpl_power_lane.sv =====
// One motor's input power model, four register stages.
// Depends on cpl_pkg.
module cpl_power_lane import cpl_pkg::*;
(
    input  logic               clk,
    input  cfg_t               cfg,
    input  logic signed [15:0] cur,
    input  logic signed [15:0] speed,
    output pwr_t               pwr
);

    q_t                 t_reg, wmc1_reg, ww_reg;
    logic signed [15:0] cur1_reg, cur2_reg, cur3_reg;
    q_t                 pm_reg, kw2_reg, tt_reg, w2_reg, wmc2_reg;
    q_t                 pm3_reg, kw23_reg, kt2_reg, kw2a_reg, w23_reg, wmc3_reg;
    q_t                 pin_reg, kw2a4_reg, w24_reg, wmc4_reg;
    logic signed [15:0] cur4_reg;

    // Stage 1: torque, speed term, squared speed
    always_ff @(posedge clk)
    begin
        t_reg    <= sat32(WIDE_W'(cfg.tc) * WIDE_W'(cur));
        wmc1_reg <= sat32(WIDE_W'(speed) * WIDE_W'(cfg.mc));
        ww_reg   <= 32'(WIDE_W'(speed) * WIDE_W'(speed));
        cur1_reg <= cur;
    end

    // Stage 2: mechanical power, speed loss, t^2, (w*Mc)^2
    always_ff @(posedge clk)
    begin
        pm_reg   <= qmul(wmc1_reg, t_reg);
        kw2_reg  <= sat32((WIDE_W'(ww_reg) * WIDE_W'(cfg.kw)) >>> 16);
        tt_reg   <= qmul(t_reg, t_reg);
        w2_reg   <= qmul(wmc1_reg, wmc1_reg);
        wmc2_reg <= wmc1_reg;
        cur2_reg <= cur1_reg;
    end

    // Stage 3: copper loss, speed loss plus static loss
    always_ff @(posedge clk)
    begin
        kt2_reg  <= qmul(tt_reg, cfg.kt);
        kw2a_reg <= sat32(WIDE_W'(kw2_reg) + WIDE_W'(cfg.a));
        pm3_reg  <= pm_reg;
        kw23_reg <= kw2_reg;
        w23_reg  <= w2_reg;
        wmc3_reg <= wmc2_reg;
        cur3_reg <= cur2_reg;
    end

    // Stage 4: total input power of this motor
    always_ff @(posedge clk)
    begin
        pin_reg   <= sat32(WIDE_W'(cfg.a) + WIDE_W'(pm3_reg) + WIDE_W'(kw23_reg)
                           + WIDE_W'(kt2_reg));
        kw2a4_reg <= kw2a_reg;
        w24_reg   <= w23_reg;
        wmc4_reg  <= wmc3_reg;
        cur4_reg  <= cur3_reg;
    end

    assign pwr = '{pin: pin_reg, wmc: wmc4_reg, w2: w24_reg, kw2a: kw2a4_reg,
                   cur: cur4_reg};

endmodule

// ===== hdl/cpl_total_merge.sv =====
// Sums the motor powers and compares against the budget, one register stage.
// Depends on cpl_pkg.
module cpl_total_merge import cpl_pkg::*;
(
    input  logic             clk,
    input  q_t               pin [MOTOR_COUNT],
    input  logic [31:0]      budget,
    output logic [DEN_W-1:0] total,
    output logic             limited
);

    logic signed [TOT_W-1:0] sum;
    logic signed [CMP_W-1:0] sum_ext, bud_ext;
    logic [DEN_W-1:0]        total_reg;
    logic                    limited_reg;

    // Exact total and budget compare
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
            sum = sum + TOT_W'(pin[i]);
        sum_ext = CMP_W'(sum);
        bud_ext = $signed(CMP_W'(budget));
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= sum[DEN_W-1:0];
        limited_reg <= (sum_ext > bud_ext);
    end

    assign total   = total_reg;
    assign limited = limited_reg;

endmodule

// ===== hdl/cpl_solve_lane.sv =====
// One motor's limiting path: scaled power, pipelined divide, discriminant,
// pipelined square root, torque and current conversion. Depends on cpl_pkg.
module cpl_solve_lane import cpl_pkg::*;
(
    input  logic             clk,
    input  cfg_t             cfg,
    input  pwr_t             pwr,
    input  logic [31:0]      budget,
    input  logic [DEN_W-1:0] total,
    input  logic             limited,
    output res_t             res
);

    localparam int TAIL   = 12;
    localparam int T_SQ0  = 3;
    localparam int T_LAST = TAIL - 1;

    typedef struct packed {
        q_t                 wmc;
        q_t                 w2;
        q_t                 kw2a;
        logic signed [15:0] cur;
        logic               neg;
        logic               lim;
        logic               clamp;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [31:0]      work;
        logic [31:0]      quo;
    } div_t;

    typedef struct packed {
        logic [SQREM_W-1:0] rem;
        logic [ROOT_W-1:0]  root;
        logic [RAD_W-1:0]   rad;
    } sq_t;

    // Restoring division, DIV_BITS quotient bits
    function automatic div_t div_step(input div_t d, input logic [DEN_W-1:0] den);
        logic [REM_W-1:0] r2;
        div_t             r;
        r = d;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r2     = {r.rem[REM_W-2:0], r.work[31]};
            r.work = {r.work[30:0], 1'b0};
            if (r2 >= REM_W'(den))
            begin
                r.rem = r2 - REM_W'(den);
                r.quo = {r.quo[30:0], 1'b1};
            end
            else
            begin
                r.rem = r2;
                r.quo = {r.quo[30:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Digit-by-digit square root, SQ_BITS root bits
    function automatic sq_t sq_step(input sq_t s);
        logic [SQREM_W-1:0] r2;
        logic [SQREM_W-1:0] trial;
        sq_t                r;
        r = s;
        for (int k = 0; k < SQ_BITS; k++)
        begin
            r2    = {r.rem[SQREM_W-3:0], r.rad[RAD_W-1:RAD_W-2]};
            trial = {1'b0, r.root, 2'b01};
            r.rad = {r.rad[RAD_W-3:0], 2'b00};
            if (r2 >= trial)
            begin
                r.rem  = r2 - trial;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r.rem  = r2;
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [63:0]       num_reg;
    side_t             side0_reg;
    div_t              d_reg    [DIV_STG];
    logic [DEN_W-1:0]  den_reg  [DIV_STG];
    side_t             dside_reg[DIV_STG];
    side_t             tside_reg[TAIL];
    q_t                e2_reg, e3_reg;
    logic [30:0]       disc_reg;
    sq_t               sq_reg   [SQ_STG];
    q_t                r_reg, m1_reg, q_reg;
    res_t              res_reg;

    logic [31:0]              pu, pmag;
    div_t                     d_start;
    logic signed [32:0]       pval;
    q_t                       four_kt, disc, negw;
    side_t                    side2;
    logic signed [WIDE_W-1:0] sqv;
    logic signed [16:0]       c;
    logic                     clip;
    logic signed [15:0]       c_sat;

    // Scaled-power numerator magnitude and sign
    always_comb
    begin
        pu   = pwr.pin;
        pmag = pu[31] ? (~pu + 32'd1) : pu;
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= 64'(pmag) * 64'(budget);
        side0_reg <= '{wmc: pwr.wmc, w2: pwr.w2, kw2a: pwr.kw2a, cur: pwr.cur,
                       neg: pwr.pin[31], lim: 1'b0, clamp: 1'b0};
    end

    // Divider pipeline; quotient stays below 2^31 since budget < total
    assign d_start = '{rem: REM_W'(num_reg[62:32]), work: num_reg[31:0], quo: '0};

    always_ff @(posedge clk)
    begin
        d_reg[0]     <= div_step(d_start, total);
        den_reg[0]   <= total;
        dside_reg[0] <= '{wmc: side0_reg.wmc, w2: side0_reg.w2, kw2a: side0_reg.kw2a,
                          cur: side0_reg.cur, neg: side0_reg.neg, lim: limited,
                          clamp: 1'b0};
        for (int s = 1; s < DIV_STG; s++)
        begin
            d_reg[s]     <= div_step(d_reg[s-1], den_reg[s-1]);
            den_reg[s]   <= den_reg[s-1];
            dside_reg[s] <= dside_reg[s-1];
        end
    end

    // Signed scaled power, quadratic coefficients, discriminant
    always_comb
    begin
        pval    = $signed({1'b0, d_reg[DIV_STG-1].quo});
        if (dside_reg[DIV_STG-1].neg)
            pval = -pval;
        four_kt = sat32(WIDE_W'(cfg.kt) * WIDE_W'(QUAD_FACTOR));
        disc    = sat32(WIDE_W'(tside_reg[1].w2) - WIDE_W'(e3_reg));
        side2       = tside_reg[1];
        side2.clamp = disc[31];
    end

    // Side data shift line for the tail stages; clamp flag joins at stage 2
    always_ff @(posedge clk)
    begin
        tside_reg[0] <= dside_reg[DIV_STG-1];
        tside_reg[1] <= tside_reg[0];
        tside_reg[2] <= side2;
        for (int i = 3; i < TAIL; i++)
            tside_reg[i] <= tside_reg[i-1];
    end

    always_ff @(posedge clk)
    begin
        e2_reg   <= sat32(WIDE_W'(dside_reg[DIV_STG-1].kw2a) - WIDE_W'(pval));
        e3_reg   <= qmul(four_kt, e2_reg);
        disc_reg <= disc[31] ? '0 : disc[30:0];
    end

    // Square root pipeline
    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_step('{rem: '0, root: '0, rad: {1'b0, disc_reg, 16'd0}});
        for (int s = 1; s < SQ_STG; s++)
            sq_reg[s] <= sq_step(sq_reg[s-1]);
    end

    // Root selection by command sign, then back to current
    always_comb
    begin
        negw = sat32(-WIDE_W'(tside_reg[T_SQ0+SQ_STG-1].wmc));
        sqv  = $signed(WIDE_W'(sq_reg[SQ_STG-1].root));
    end

    always_ff @(posedge clk)
    begin
        if (tside_reg[T_SQ0+SQ_STG-1].cur <= 16'sd0)
            r_reg <= sat32(WIDE_W'(negw) - sqv);
        else
            r_reg <= sat32(WIDE_W'(negw) + sqv);
        m1_reg <= qmul(r_reg, cfg.inv2kt);
        q_reg  <= qmul(m1_reg, cfg.ic);
    end

    // Truncate toward zero and clip to the command range
    always_comb
    begin
        c = 17'($signed(q_reg[31:16]))
            + 17'((q_reg[31] && (q_reg[15:0] != 16'd0)) ? 1 : 0);
        clip  = 1'b0;
        c_sat = c[15:0];
        if (c > 17'(CMD_MAX))
        begin
            c_sat = 16'(CMD_MAX);
            clip  = 1'b1;
        end
        else if (c < 17'(-CMD_MAX))
        begin
            c_sat = 16'(-CMD_MAX);
            clip  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.current <= tside_reg[T_LAST].lim ? c_sat : tside_reg[T_LAST].cur;
        res_reg.sat     <= tside_reg[T_LAST].lim & (clip | tside_reg[T_LAST].clamp);
        res_reg.limited <= tside_reg[T_LAST].lim;
    end

    assign res = res_reg;

endmodule

// ===== hdl/chassis_power_limiter_unit.sv =====
// Top level of the chassis power limiter: config registers, lanes, merge.
// Depends on cpl_pkg, cpl_power_lane, cpl_total_merge, cpl_solve_lane.
//
// Takes one item (four current commands, four speeds, budget) every clock
// cycle; busy is always low. Each item's result appears, in input order, on
// a one-cycle done strobe. The depth is set by the 32-bit pipelined divider
// for the budget/total scaling (8 stages) and the pipelined 24-bit square
// root (6 stages) in each of the four motor lanes. The receiver cannot
// stall the pipeline and must take every done cycle. Configuration writes
// are always ready and must be made only while no items are in flight; an
// index of 7 is ignored.
module chassis_power_limiter_unit import cpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [15:0] cmd_current_0,
    input  logic signed [15:0] cmd_current_1,
    input  logic signed [15:0] cmd_current_2,
    input  logic signed [15:0] cmd_current_3,
    input  logic signed [15:0] wheel_speed_0,
    input  logic signed [15:0] wheel_speed_1,
    input  logic signed [15:0] wheel_speed_2,
    input  logic signed [15:0] wheel_speed_3,
    input  logic [31:0]        power_budget,
    output logic               done,
    output logic signed [15:0] limited_current_0,
    output logic signed [15:0] limited_current_1,
    output logic signed [15:0] limited_current_2,
    output logic signed [15:0] limited_current_3,
    output logic               was_limited,
    output logic               was_saturated
);

`include "chassis_power_limiter_unit_defines.svh"

    cfg_t               cfg_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [31:0]        bud_reg [PWR_LAT];
    logic               done_reg, lim_reg, sat_reg;
    logic signed [15:0] out_reg [MOTOR_COUNT];

    logic signed [15:0] cmd_arr   [MOTOR_COUNT];
    logic signed [15:0] speed_arr [MOTOR_COUNT];
    pwr_t               pwr       [MOTOR_COUNT];
    q_t                 pin       [MOTOR_COUNT];
    res_t               res       [MOTOR_COUNT];
    logic [DEN_W-1:0]   total;
    logic               limited;
    logic               any_sat;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign cmd_arr[0]   = cmd_current_0;
    assign cmd_arr[1]   = cmd_current_1;
    assign cmd_arr[2]   = cmd_current_2;
    assign cmd_arr[3]   = cmd_current_3;
    assign speed_arr[0] = wheel_speed_0;
    assign speed_arr[1] = wheel_speed_1;
    assign speed_arr[2] = wheel_speed_2;
    assign speed_arr[3] = wheel_speed_3;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TORQUE_PER_CURRENT:  cfg_reg.tc     <= cfg_data;
                REG_SPEED_POWER_FACTOR:  cfg_reg.mc     <= cfg_data;
                REG_CURRENT_PER_TORQUE:  cfg_reg.ic     <= cfg_data;
                REG_SPEED_LOSS_GAIN:     cfg_reg.kw     <= cfg_data;
                REG_TORQUE_LOSS_GAIN:    cfg_reg.kt     <= cfg_data;
                REG_STATIC_LOSS:         cfg_reg.a      <= cfg_data;
                REG_INV_TWO_TORQUE_GAIN: cfg_reg.inv2kt <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[PIPE_LAT-2:0], start & ~busy};
            done_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // Budget delay to the merge stage
    always_ff @(posedge clk)
    begin
        bud_reg[0] <= power_budget;
        for (int i = 1; i < PWR_LAT; i++)
            bud_reg[i] <= bud_reg[i-1];
    end

    // Motor lanes
    for (genvar g = 0; g < MOTOR_COUNT; g++)
    begin : gen_lane
        cpl_power_lane u_power (
            .clk   (clk),
            .cfg   (cfg_reg),
            .cur   (cmd_arr[g]),
            .speed (speed_arr[g]),
            .pwr   (pwr[g])
        );

        assign pin[g] = pwr[g].pin;

        cpl_solve_lane u_solve (
            .clk     (clk),
            .cfg     (cfg_reg),
            .pwr     (pwr[g]),
            .budget  (bud_reg[PWR_LAT-1]),
            .total   (total),
            .limited (limited),
            .res     (res[g])
        );
    end

    cpl_total_merge u_merge (
        .clk     (clk),
        .pin     (pin),
        .budget  (bud_reg[PWR_LAT-1]),
        .total   (total),
        .limited (limited)
    );

    // Flag merge and result register
    always_comb
    begin
        any_sat = 1'b0;
        for (int i = 0; i < MOTOR_COUNT; i++)
            any_sat = any_sat | res[i].sat;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MOTOR_COUNT; i++)
            out_reg[i] <= res[i].current;
        lim_reg <= res[0].limited;
        sat_reg <= any_sat;
    end

    assign done              = done_reg;
    assign limited_current_0 = out_reg[0];
    assign limited_current_1 = out_reg[1];
    assign limited_current_2 = out_reg[2];
    assign limited_current_3 = out_reg[3];
    assign was_limited       = lim_reg;
    assign was_saturated     = sat_reg;

    // Checks; done is sampled at the edge that takes the result
    `CPL_ASSERT_DLY(a_latency, start && !busy, PIPE_LAT + 1, done, "item result missing")
    `CPL_ASSERT_IMP(a_sat_needs_lim, done, !(was_saturated && !was_limited), "sat without limit")
    `CPL_ASSERT_IMP(a_range, done && was_limited, (limited_current_0 >= -16'sd16384) && (limited_current_0 <= 16'sd16384) && (limited_current_3 >= -16'sd16384) && (limited_current_3 <= 16'sd16384), "limited current out of range")

endmodule
